/* hdl/ljic_pkg.sv */
// shared types, constants and codes for the lennard-jones insertion check
package ljic_pkg;

   // storage depth of the particle position memory
   localparam int MAX_PARTICLES = 1024;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = 11;

   // widths of the fixed point quantities
   localparam int POS_W  = 24;
   localparam int REC_W  = 25;
   localparam int THR_W  = 32;
   localparam int EN_W   = 48;
   localparam int R2_W   = 51;
   localparam int INV2_W = 31;
   localparam int MUL_W  = 34;

   // configuration register indexes
   localparam logic [2:0] CSR_BOX_X   = 3'd0;
   localparam logic [2:0] CSR_BOX_Y   = 3'd1;
   localparam logic [2:0] CSR_BOX_Z   = 3'd2;
   localparam logic [2:0] CSR_RECIP_X = 3'd3;
   localparam logic [2:0] CSR_RECIP_Y = 3'd4;
   localparam logic [2:0] CSR_RECIP_Z = 3'd5;
   localparam logic [2:0] CSR_THRESH  = 3'd6;
   localparam logic [2:0] CSR_TARGET  = 3'd7;

   // result status codes
   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0] trial_x;
      logic [POS_W-1:0] trial_y;
      logic [POS_W-1:0] trial_z;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [CNT_W-1:0]        placed_count;
      logic signed [EN_W-1:0]  trial_sum;
      logic signed [EN_W-1:0]  total_energy;
   } rsp_type;

   // divider control between sequencer and divider
   typedef struct packed {
      logic            start;
      logic [R2_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [INV2_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* hdl/ljic_mul.sv */
// shared signed multiplier with registered product
module ljic_mul
   import ljic_pkg::*;
(
   input  logic                        clock,
   input  logic signed [MUL_W-1:0]     mul_a,
   input  logic signed [MUL_W-1:0]     mul_b,
   output logic signed [2*MUL_W-1:0]   mul_p
);

   logic signed [2*MUL_W-1:0] prod_ff;

   // one product per cycle, registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

/* hdl/ljic_div.sv */
// bit-serial restoring divider computing 2^60 / r2 for r2 >= 2^30
module ljic_div
   import ljic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [R2_W-1:0]   rem_ff;
   logic [R2_W-1:0]   dvs_ff;
   logic [INV2_W-1:0] quo_ff;
   logic [4:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [R2_W:0]     trial_rem;
   logic              take;

   // shift in a zero dividend bit and try the subtract
   always_comb begin
      trial_rem = {rem_ff, 1'b0};
      take      = (trial_rem >= {1'b0, dvs_ff});
   end

   // upper dividend bits leave remainder 2^29, then 31 quotient bits follow
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(INV2_W);
            rem_ff  <= R2_W'(1) << 29;
            dvs_ff  <= div_req.divisor;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            if (take) begin
               rem_ff <= R2_W'(trial_rem - {1'b0, dvs_ff});
            end else begin
               rem_ff <= trial_rem[R2_W-1:0];
            end
            quo_ff <= {quo_ff[INV2_W-2:0], take};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* hdl/lj_insertion_energy_check_core.sv */
// lennard-jones insertion check: sequencer, position memory and accumulators
// sequence: a full or empty store is answered from the idle state; otherwise each stored
//   particle walked takes a memory read, 12 multiplier steps, the divider, the energy products
//   and an accumulate; a pair closer than r^2 = 0.25 skips the divider and the products
// throughput: one transaction at a time, next accepted after the result is taken
// reset: synchronous, clears count and total energy and loads register defaults;
//   the position memory is not cleared, only entries below the count are read
module lj_insertion_energy_check_core
   import ljic_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_WAIT, S_M1, S_M2, S_M3, S_M4, S_DIV,
      S_E1, S_E2, S_E3, S_E4, S_ACC, S_OUT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [POS_W-1:0]        box_x_ff, box_y_ff, box_z_ff;
   logic [REC_W-1:0]        rec_x_ff, rec_y_ff, rec_z_ff;
   logic signed [THR_W-1:0] thr_ff;
   logic [CNT_W-1:0]        target_ff;

   // walk state
   req_type                 trial_ff;
   logic [3*POS_W-1:0]      pos_ff;
   logic [IDX_W-1:0]        j_ff;
   logic [1:0]              axis_ff;
   logic signed [24:0]      d_ff;
   logic [R2_W-1:0]         r2_ff;
   logic [INV2_W-1:0]       inv2_ff;
   logic signed [THR_W-1:0] e_ff;
   logic signed [EN_W-1:0]  sum_ff;
   logic [CNT_W-1:0]        count_ff;
   logic signed [EN_W-1:0]  total_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;

   logic [3*POS_W-1:0]      mem [MAX_PARTICLES];
   logic                    mem_we;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   logic [POS_W-1:0]        t_ax, p_ax, len_ax;
   logic [REC_W-1:0]        rec_ax;
   logic signed [24:0]      d_comb;
   logic signed [2*MUL_W-1:0] rnd;
   logic signed [MUL_W-1:0] n_comb;
   logic signed [35:0]      im_full;
   logic signed [25:0]      im_sat;
   logic [R2_W-1:0]         r2_next;
   logic [32:0]             inv4;
   logic [22:0]             e6;
   logic signed [EN_W-1:0]  sum_next;
   logic signed [EN_W:0]    tot_wide;
   logic signed [EN_W-1:0]  tot_sat;
   logic                    is_full;

   ljic_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   ljic_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // per-axis operand selection
   always_comb begin
      unique case (axis_ff)
         2'd0: begin
            t_ax = trial_ff.trial_x; p_ax = pos_ff[3*POS_W-1:2*POS_W];
            len_ax = box_x_ff; rec_ax = rec_x_ff;
         end
         2'd1: begin
            t_ax = trial_ff.trial_y; p_ax = pos_ff[2*POS_W-1:POS_W];
            len_ax = box_y_ff; rec_ax = rec_y_ff;
         end
         default: begin
            t_ax = trial_ff.trial_z; p_ax = pos_ff[POS_W-1:0];
            len_ax = box_z_ff; rec_ax = rec_z_ff;
         end
      endcase
   end

   // minimum image, squared distance and power chain arithmetic
   always_comb begin
      d_comb  = $signed({1'b0, t_ax}) - $signed({1'b0, p_ax});
      rnd     = mul_p + (68'sd1 <<< 39);
      n_comb  = {{6{rnd[67]}}, rnd[67:40]};
      im_full = 36'(d_ff) - mul_p[35:0];
      if (im_full > 36'sd16777216) begin
         im_sat = 26'sd16777216;
      end else if (im_full < -36'sd16777216) begin
         im_sat = -26'sd16777216;
      end else begin
         im_sat = im_full[25:0];
      end
      r2_next  = r2_ff + mul_p[R2_W-1:0];
      inv4     = mul_p[60:28];
      e6       = mul_p[62:40];
      sum_next = sum_ff + EN_W'(e_ff);
      tot_wide = (EN_W+1)'(total_ff) + (EN_W+1)'(sum_next);
      if (tot_wide[EN_W] != tot_wide[EN_W-1]) begin
         tot_sat = tot_wide[EN_W] ? {1'b1, {(EN_W-1){1'b0}}} : {1'b0, {(EN_W-1){1'b1}}};
      end else begin
         tot_sat = tot_wide[EN_W-1:0];
      end
      is_full = (count_ff >= target_ff) || (count_ff >= CNT_W'(MAX_PARTICLES));
   end

   // shared multiplier operands by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_M1: begin mul_a = MUL_W'(d_comb); mul_b = $signed({9'd0, rec_ax}); end
         S_M2: begin mul_a = $signed({10'd0, len_ax}); mul_b = n_comb; end
         S_M3: begin mul_a = MUL_W'(im_sat); mul_b = MUL_W'(im_sat); end
         S_E1: begin
            mul_a = $signed({3'd0, inv2_ff}); mul_b = $signed({3'd0, inv2_ff});
         end
         S_E2: begin mul_a = $signed({1'b0, inv4}); mul_b = $signed({3'd0, inv2_ff}); end
         S_E3: begin
            mul_a = $signed({11'd0, e6});
            mul_b = $signed({11'd0, e6}) - 34'sd65536;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // divider start at the last axis when the pair is not saturated
   always_comb begin
      div_req.start   = (state_ff == S_M4) && (axis_ff == 2'd2)
                        && (r2_next >= (R2_W'(1) << 30));
      div_req.divisor = r2_next;
   end

   assign mem_we = ((state_ff == S_IDLE) && req_valid && !is_full && (count_ff == '0))
                || ((state_ff == S_ACC) && !(e_ff > thr_ff)
                    && ({1'b0, j_ff} + CNT_W'(1) == count_ff));

   // position memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= (state_ff == S_IDLE) ? req_data : trial_ff;
      end
      pos_ff <= mem[j_ff];
   end

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff  <= '1;
         box_y_ff  <= '1;
         box_z_ff  <= '1;
         rec_x_ff  <= REC_W'(1);
         rec_y_ff  <= REC_W'(1);
         rec_z_ff  <= REC_W'(1);
         thr_ff    <= 32'sd491520;
         target_ff <= CNT_W'(1024);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BOX_X:   box_x_ff  <= csr_data[POS_W-1:0];
            CSR_BOX_Y:   box_y_ff  <= csr_data[POS_W-1:0];
            CSR_BOX_Z:   box_z_ff  <= csr_data[POS_W-1:0];
            CSR_RECIP_X: rec_x_ff  <= csr_data[REC_W-1:0];
            CSR_RECIP_Y: rec_y_ff  <= csr_data[REC_W-1:0];
            CSR_RECIP_Z: rec_z_ff  <= csr_data[REC_W-1:0];
            CSR_THRESH:  thr_ff    <= $signed(csr_data);
            CSR_TARGET:  target_ff <= csr_data[CNT_W-1:0];
            default:     target_ff <= target_ff;
         endcase
      end
   end

   // sequencer with walk state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         axis_ff      <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  trial_ff <= req_data;
                  j_ff     <= '0;
                  sum_ff   <= '0;
                  if (is_full) begin
                     rsp_ff       <= '{ST_FULL, count_ff, '0, total_ff};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_OUT;
                  end else if (count_ff == '0) begin
                     count_ff     <= count_ff + CNT_W'(1);
                     rsp_ff       <= '{ST_ACCEPT, count_ff + CNT_W'(1), '0, total_ff};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_OUT;
                  end else begin
                     state_ff <= S_WAIT;
                  end
               end
            end
            S_WAIT: begin
               axis_ff  <= '0;
               r2_ff    <= '0;
               state_ff <= S_M1;
            end
            S_M1: begin
               d_ff     <= d_comb;
               state_ff <= S_M2;
            end
            S_M2: state_ff <= S_M3;
            S_M3: state_ff <= S_M4;
            S_M4: begin
               r2_ff <= r2_next;
               if (axis_ff != 2'd2) begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_M1;
               end else if (r2_next < (R2_W'(1) << 30)) begin
                  e_ff     <= 32'sh7FFFFFFF;
                  state_ff <= S_ACC;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  inv2_ff  <= div_rsp.quotient;
                  state_ff <= S_E1;
               end
            end
            S_E1: state_ff <= S_E2;
            S_E2: state_ff <= S_E3;
            S_E3: state_ff <= S_E4;
            S_E4: begin
               e_ff     <= mul_p[45:14];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               sum_ff <= sum_next;
               if (e_ff > thr_ff) begin
                  rsp_ff       <= '{ST_REJECT, count_ff, sum_next, total_ff};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else if ({1'b0, j_ff} + CNT_W'(1) == count_ff) begin
                  count_ff     <= count_ff + CNT_W'(1);
                  total_ff     <= tot_sat;
                  rsp_ff       <= '{ST_ACCEPT, count_ff + CNT_W'(1), sum_next, tot_sat};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else begin
                  j_ff     <= j_ff + IDX_W'(1);
                  state_ff <= S_WAIT;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a new transaction is never taken while a result is pending
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("req_ready with pending result");

   // stored count never passes the memory depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PARTICLES)) else $error("count overflow");

   // an accepted result always comes with exactly one new stored particle
   a_accept_grows: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && rsp_data.status == ST_ACCEPT)
         |-> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accept without count increment");

   // the divider is only started on unsaturated pairs
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> div_req.divisor >= (R2_W'(1) << 30))
      else $error("divider started with small r2");

endmodule

/* dv/lj_insertion_energy_check_scoreboard.sv */
// checker for the lennard-jones insertion core: predicts each trial and compares results
module lj_insertion_energy_check_scoreboard
   import ljic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          placed
);

   localparam longint TOTAL_MAX = 64'sd140737488355327;
   localparam longint TOTAL_MIN = -64'sd140737488355328;

   // mirrored registers
   logic [POS_W-1:0] box_len [3];
   logic [REC_W-1:0] box_rcp [3];
   logic signed [THR_W-1:0] max_pair_energy;
   logic [CNT_W-1:0] target_particles;

   // mirrored particle state
   logic [POS_W-1:0] placed_pos [MAX_PARTICLES][3];
   int unsigned placed_n;
   longint energy_acc;

   rsp_type expected_results[$];

   // minimum image distance along one axis
   function automatic longint min_image(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                                        logic [POS_W-1:0] len, logic [REC_W-1:0] rcp);
      longint d;
      longint n;
      longint im;
      d = longint'(a) - longint'(b);
      n = (d * longint'(rcp) + (64'sd1 <<< 39)) >>> 40;
      im = d - longint'(len) * n;
      if (im > (64'sd1 <<< 24)) im = 64'sd1 <<< 24;
      if (im < -(64'sd1 <<< 24)) im = -(64'sd1 <<< 24);
      return im;
   endfunction

   // lj pair energy in q16.16, saturating for close pairs
   function automatic longint lj_energy(longint unsigned r2);
      longint unsigned inv2;
      longint unsigned inv4;
      longint unsigned inv6;
      longint e6;
      if (r2 < (64'd1 << 30)) return 64'sd2147483647;
      inv2 = (64'd1 << 60) / r2;
      inv4 = (inv2 * inv2) >> 28;
      inv6 = (inv4 * inv2) >> 28;
      e6 = longint'(inv6 >> 12);
      return (4 * e6 * (e6 - 65536)) >>> 16;
   endfunction

   // walk stored particles for one trial and update the mirrored state
   function automatic rsp_type insertion_result(req_type t);
      rsp_type r;
      logic [POS_W-1:0] tp [3];
      longint sum;
      longint e;
      longint dd;
      longint unsigned r2;
      logic [1:0] st;
      tp[0] = t.trial_x;
      tp[1] = t.trial_y;
      tp[2] = t.trial_z;
      sum = 0;
      st = ST_ACCEPT;
      if (placed_n >= target_particles || placed_n >= MAX_PARTICLES) begin
         st = ST_FULL;
      end else begin
         for (int j = 0; j < placed_n; j++) begin
            r2 = 0;
            for (int k = 0; k < 3; k++) begin
               dd = min_image(tp[k], placed_pos[j][k], box_len[k], box_rcp[k]);
               r2 += longint'(dd * dd);
            end
            e = lj_energy(r2);
            sum += e;
            if (e > longint'(max_pair_energy)) begin
               st = ST_REJECT;
               break;
            end
         end
         if (st == ST_ACCEPT) begin
            energy_acc = energy_acc + sum;
            if (energy_acc > TOTAL_MAX) energy_acc = TOTAL_MAX;
            if (energy_acc < TOTAL_MIN) energy_acc = TOTAL_MIN;
            for (int k = 0; k < 3; k++) placed_pos[placed_n][k] = tp[k];
            placed_n++;
         end
      end
      r.status = st;
      r.placed_count = placed_n[CNT_W-1:0];
      r.trial_sum = sum[EN_W-1:0];
      r.total_energy = energy_acc[EN_W-1:0];
      return r;
   endfunction

   assign pending = expected_results.size();
   assign placed = placed_n;

   // track registers, predict on trial transactions, compare on result transactions
   always @(posedge clock) begin
      rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            box_len[k] = '1;
            box_rcp[k] = REC_W'(1);
         end
         max_pair_energy = 491520;
         target_particles = CNT_W'(1024);
         placed_n = 0;
         energy_acc = 0;
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BOX_X:   box_len[0] = csr_data[POS_W-1:0];
               CSR_BOX_Y:   box_len[1] = csr_data[POS_W-1:0];
               CSR_BOX_Z:   box_len[2] = csr_data[POS_W-1:0];
               CSR_RECIP_X: box_rcp[0] = csr_data[REC_W-1:0];
               CSR_RECIP_Y: box_rcp[1] = csr_data[REC_W-1:0];
               CSR_RECIP_Z: box_rcp[2] = csr_data[REC_W-1:0];
               CSR_THRESH:  max_pair_energy = csr_data;
               CSR_TARGET:  target_particles = csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no expectation waiting");
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (want.status !== rsp_data.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_data.status);
                  errs++;
               end
               if (want.placed_count !== rsp_data.placed_count) begin
                  $error("placed_count expected %0d got %0d",
                         want.placed_count, rsp_data.placed_count);
                  errs++;
               end
               if (want.trial_sum !== rsp_data.trial_sum) begin
                  $error("trial_sum expected %0d got %0d", want.trial_sum, rsp_data.trial_sum);
                  errs++;
               end
               if (want.total_energy !== rsp_data.total_energy) begin
                  $error("total_energy expected %0d got %0d",
                         want.total_energy, rsp_data.total_energy);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
         if (req_valid && req_ready) expected_results.push_back(insertion_result(req_data));
      end
   end

endmodule

/* dv/lj_insertion_energy_check_core_tb.sv */
// testbench top for the lennard-jones insertion core: stimulus, stalls and verdict
module lj_insertion_energy_check_core_tb;
   import ljic_pkg::*;

   localparam int TRIAL_GOAL = 290;
   localparam int PLACE_CAP  = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          fail_count;
   int          pending;
   int          placed;
   int          trials_sent;
   logic        stall_enable;

   lj_insertion_energy_check_core dut (.*);

   lj_insertion_energy_check_scoreboard checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #30000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      int stall_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (stall_enable && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   task automatic send_trial(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
      int gap;
      req_valid <= 1'b1;
      req_data <= '{trial_x: x, trial_y: y, trial_z: z};
      do @(posedge clock); while (!req_ready);
      trials_sent++;
      gap = stall_enable ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid and wait until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic write_box(int axis, logic [POS_W-1:0] len, logic [REC_W-1:0] rcp);
      case (axis)
         0: begin
            write_reg(CSR_BOX_X, 32'(len));
            write_reg(CSR_RECIP_X, 32'(rcp));
         end
         1: begin
            write_reg(CSR_BOX_Y, 32'(len));
            write_reg(CSR_RECIP_Y, 32'(rcp));
         end
         default: begin
            write_reg(CSR_BOX_Z, 32'(len));
            write_reg(CSR_RECIP_Z, 32'(rcp));
         end
      endcase
   endtask

   initial begin
      logic [POS_W-1:0] len [3];
      logic [31:0] thr;
      int tgt;
      int n;
      int mode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BOX_X;
      csr_data = '0;
      stall_enable = 1'b0;
      trials_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: register defaults, empty store, coincident pair, far corner
      send_trial(24'h0, 24'h0, 24'h0);
      send_trial(24'h0, 24'h0, 24'h0);
      send_trial(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_trial(24'h010000, 24'h008000, 24'h0);
      send_trial(24'h800000, 24'h7FFFFF, 24'h000001);
      drain();

      // threshold at maximum lets a saturated pair through
      write_reg(CSR_THRESH, 32'h7FFFFFFF);
      send_trial(24'h0, 24'h0, 24'h0);
      drain();

      // threshold at minimum rejects on the first pair
      write_reg(CSR_THRESH, 32'h80000000);
      send_trial(24'h123456, 24'hABCDEF, 24'h555555);
      send_trial(24'hAAAAAA, 24'h0F0F0F, 24'hF0F0F0);
      drain();

      // inconsistent box and reciprocal: zero box with large reciprocal, zero reciprocal
      write_box(0, 24'h0, 25'h1000000);
      write_box(1, 24'hFFFFFF, 25'h1000000);
      write_box(2, 24'h020000, 25'h0);
      write_reg(CSR_THRESH, 32'h00070000);
      send_trial(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
      send_trial(24'h7FFFFF, 24'hFFFFFF, 24'h800000);
      send_trial(24'h030000, 24'h050000, 24'h0);
      drain();

      // zero target means always full
      write_reg(CSR_TARGET, 32'd0);
      send_trial(24'h010000, 24'h020000, 24'h030000);
      send_trial(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      drain();

      // target reached exactly
      write_reg(CSR_TARGET, 32'(placed));
      send_trial(24'h040000, 24'h040000, 24'h0);
      drain();

      // random phases with small boxes, bounded store growth
      stall_enable = 1'b1;
      while (trials_sent < TRIAL_GOAL) begin
         for (int k = 0; k < 3; k++) begin
            len[k] = 24'($urandom_range(24'h020000, 24'h100000));
            if ($urandom_range(0, 7) == 0)
               write_box(k, 24'($urandom_range(0, 24'hFFFFFF)),
                         25'($urandom_range(0, 25'h1000000)));
            else
               write_box(k, len[k], 25'((64'd1 << 40) / len[k]));
         end
         mode = $urandom_range(0, 9);
         if (mode == 0) thr = 32'h7FFFFFFF;
         else if (mode == 1) thr = $urandom();
         else thr = $urandom_range(0, 32'h000C0000) - 32'h00010000;
         write_reg(CSR_THRESH, thr);
         tgt = placed + $urandom_range(0, 5);
         if (tgt > PLACE_CAP) tgt = PLACE_CAP;
         if ($urandom_range(0, 9) == 0) tgt = 1024;
         write_reg(CSR_TARGET, 32'(tgt));
         stall_enable = $urandom_range(0, 4) != 0;
         n = $urandom_range(15, 30);
         for (int i = 0; i < n && trials_sent < TRIAL_GOAL; i++) begin
            if (tgt > PLACE_CAP && placed >= PLACE_CAP) write_reg(CSR_TARGET, 32'(PLACE_CAP));
            if ($urandom_range(0, 4) == 0)
               send_trial(24'($urandom()), 24'($urandom()),
                          $urandom_range(0, 1) ? 24'($urandom()) : 24'd0);
            else
               send_trial(24'($urandom_range(0, len[0])), 24'($urandom_range(0, len[1])),
                          $urandom_range(0, 3) == 0 ? 24'd0 : 24'($urandom_range(0, len[2])));
            if (tgt > PLACE_CAP && placed >= PLACE_CAP - 1) begin
               drain();
               write_reg(CSR_TARGET, 32'(PLACE_CAP));
               tgt = PLACE_CAP;
            end
         end
         drain();
      end

      // wind down
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/ljic_pkg.sv
hdl/ljic_mul.sv
hdl/ljic_div.sv
hdl/lj_insertion_energy_check_core.sv
dv/lj_insertion_energy_check_scoreboard.sv
dv/lj_insertion_energy_check_core_tb.sv
